/* rtl/mtet_pkg.sv */
package mtet_pkg;

    // Build-time sizing
    localparam int NUM_CHANNELS    = 6;
    localparam int RING_DEPTH      = 8;
    localparam int NUM_OFFSET_REGS = 6;

    // Field widths
    localparam int CH_W       = 3;
    localparam int RAW_W      = 13;
    localparam int RATE_W     = 14;
    localparam int TURN_W     = 16;
    localparam int CONT_W     = 30;
    localparam int ANGLE_W    = 38;
    localparam int DEG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Arithmetic constants
    localparam int JUMP_LIMIT      = 7500;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int TURN_LIMIT      = 32767;
    localparam int DEG_PER_TURN    = 360;

    // Derived memory geometry
    localparam int CH_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RING_AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_ENT  = NUM_CHANNELS * RING_DEPTH;
    localparam int RING_MAW  = (RING_ENT > 1) ? $clog2(RING_ENT) : 1;
    localparam int RING_LOG2 = $clog2(RING_DEPTH);

    // Running ring sum: |sum| <= 7500 * RING_DEPTH
    localparam int SUM_W = RATE_W + RING_LOG2;

    // Mean by reciprocal multiply: floor(n / D) = (n * ceil(2^K / D)) >> K,
    // exact for n < 2^MEAN_N with K = MEAN_N + ceil(log2 D)
    localparam int     MEAN_N     = SUM_W - 1;
    localparam int     MEAN_SH    = MEAN_N + RING_LOG2;
    localparam longint MEAN_RECIP = ((64'(1) << MEAN_SH) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int     RECIP_W    = MEAN_N + 2;

    // Per-channel record kept in the channel memory
    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic                     wrapped;
        logic [RING_AW-1:0]       pos;
        logic signed [TURN_W-1:0] turns;
        logic [RAW_W-1:0]         prev_raw;
    } t_chan_rec;

    localparam int CHAN_REC_W = $bits(t_chan_rec);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_RING,
        S_MATH,
        S_DONE
    } t_state;

endpackage

/* rtl/multi_turn_encoder_tracker.sv */
// An accepted word passes through S_CHAN, S_RING, S_MATH and S_DONE in series:
// the channel record read, the dependent ring-entry read and the registered
// mean/angle multiplies; S_DONE waits until the output register can load.
// A new word is taken in the cycle the previous result loads the output register.
// Reset (sync, active low) clears control, offsets and per-channel valid bits;
// unwritten channels read as zero, so no clearing pass is needed.
module multi_turn_encoder_tracker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [mtet_pkg::CH_W-1:0]             i_channel,
    input  logic [mtet_pkg::RAW_W-1:0]            i_raw_angle,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mtet_pkg::RATE_W-1:0]    o_step_rate,
    output logic signed [mtet_pkg::RATE_W-1:0]    o_mean_rate,
    output logic signed [mtet_pkg::TURN_W-1:0]    o_turn_count,
    output logic signed [mtet_pkg::CONT_W-1:0]    o_continuous_count,
    output logic signed [mtet_pkg::ANGLE_W-1:0]   o_angle_deg_x8192,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mtet_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mtet_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int RATE_W  = mtet_pkg::RATE_W;
    localparam int TURN_W  = mtet_pkg::TURN_W;
    localparam int RAW_W   = mtet_pkg::RAW_W;
    localparam int CONT_W  = mtet_pkg::CONT_W;
    localparam int ANGLE_W = mtet_pkg::ANGLE_W;
    localparam int SUM_W   = mtet_pkg::SUM_W;
    localparam int CH_AW   = mtet_pkg::CH_AW;
    localparam int RING_AW = mtet_pkg::RING_AW;
    localparam int RMAW    = mtet_pkg::RING_MAW;
    localparam int MEAN_N  = mtet_pkg::MEAN_N;
    localparam int RECIP_W = mtet_pkg::RECIP_W;
    localparam int DEG_W   = mtet_pkg::DEG_W;

    localparam logic signed [RATE_W:0]    JUMP_HI   = (RATE_W+1)'(mtet_pkg::JUMP_LIMIT);
    localparam logic signed [RATE_W:0]    JUMP_LO   = -JUMP_HI;
    localparam logic signed [RATE_W:0]    TURN_STEP = (RATE_W+1)'(mtet_pkg::COUNTS_PER_TURN);
    localparam logic signed [TURN_W-1:0]  TURN_MAX  = TURN_W'(mtet_pkg::TURN_LIMIT);
    localparam logic signed [TURN_W-1:0]  TURN_MIN  = -TURN_MAX;
    localparam logic signed [mtet_pkg::DEG_W-1:0] DEG =
        mtet_pkg::DEG_W'(mtet_pkg::DEG_PER_TURN);
    localparam logic [RING_AW-1:0]        POS_LAST  = RING_AW'(mtet_pkg::RING_DEPTH - 1);
    localparam logic [RECIP_W-1:0]        RECIP     = RECIP_W'(mtet_pkg::MEAN_RECIP);

    // ---------------------------------------------------------------
    // Control
    mtet_pkg::t_state r_state, n_state;
    logic in_acc;
    logic out_load;
    logic wr_en;

    // Configuration
    logic [RAW_W-1:0] r_zero_offset [mtet_pkg::NUM_OFFSET_REGS];
    logic [mtet_pkg::NUM_CHANNELS-1:0] r_ch_vld;

    // Item context
    logic [CH_AW-1:0] r_ch_idx;
    logic             r_in_range;
    logic             r_rec_vld;
    logic [RAW_W-1:0] r_raw;
    logic [RAW_W-1:0] r_offset;

    // After the channel read
    logic signed [RATE_W-1:0] r_rate;
    logic signed [TURN_W-1:0] r_turns_new;
    logic [RING_AW-1:0]       r_pos;
    logic                     r_wrapped;
    logic signed [SUM_W-1:0]  r_sum_old;
    logic [RMAW-1:0]          r_ring_addr;

    // After the ring read
    logic signed [SUM_W-1:0]  r_sum_new;
    logic signed [CONT_W:0]   r_adiff;
    logic signed [CONT_W-1:0] r_cont;

    // After the multiplies
    logic [MEAN_N+RECIP_W-1:0] r_mean_prod;
    logic                      r_sum_neg;
    logic signed [ANGLE_W-1:0] r_angle;

    // Output register
    logic                      r_out_valid;
    logic signed [RATE_W-1:0]  r_o_rate;
    logic signed [RATE_W-1:0]  r_o_mean;
    logic signed [TURN_W-1:0]  r_o_turns;
    logic signed [CONT_W-1:0]  r_o_cont;
    logic signed [ANGLE_W-1:0] r_o_angle;

    // Memories
    logic [mtet_pkg::CHAN_REC_W-1:0] chan_rdata;
    logic [RATE_W-1:0]               ring_rdata;
    logic [RMAW-1:0]                 ring_addr;
    mtet_pkg::t_chan_rec             rec_rd;
    mtet_pkg::t_chan_rec             rec_wr;

    // ---------------------------------------------------------------
    // Sequencer
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        wr_en      = 1'b0;
        case (r_state)
            mtet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = mtet_pkg::S_CHAN;
                end
            end
            mtet_pkg::S_CHAN: begin
                n_state = mtet_pkg::S_RING;
            end
            mtet_pkg::S_RING: begin
                wr_en   = r_in_range;
                n_state = mtet_pkg::S_MATH;
            end
            mtet_pkg::S_MATH: begin
                n_state = mtet_pkg::S_DONE;
            end
            mtet_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load   = 1'b1;
                    o_in_ready = 1'b1;
                    n_state    = i_in_valid ? mtet_pkg::S_CHAN : mtet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtet_pkg::S_IDLE;
            end
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtet_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mtet_pkg::NUM_OFFSET_REGS; k++) begin
                r_zero_offset[k] <= '0;
            end
        end else if (i_cfg_valid && (32'(i_cfg_index) < mtet_pkg::NUM_OFFSET_REGS)) begin
            r_zero_offset[i_cfg_index] <= i_cfg_data[RAW_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Memories: channel records and rate rings
    mtet_ram #(
        .WIDTH (mtet_pkg::CHAN_REC_W),
        .DEPTH (mtet_pkg::NUM_CHANNELS)
    ) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ch_idx),
        .i_wdata (rec_wr),
        .i_raddr (CH_AW'(i_channel)),
        .o_rdata (chan_rdata)
    );

    // Ring slot is addressed straight from the channel record in S_CHAN
    mtet_ram #(
        .WIDTH (RATE_W),
        .DEPTH (mtet_pkg::RING_ENT)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_ring_addr),
        .i_wdata (r_rate),
        .i_raddr (ring_addr),
        .o_rdata (ring_rdata)
    );

    // Records never written read as zero
    assign rec_rd = r_rec_vld ? mtet_pkg::t_chan_rec'(chan_rdata) : '0;

    // ---------------------------------------------------------------
    // Channel stage: unwrap the jump and update the turn count
    logic signed [RATE_W:0]   diff;
    logic signed [RATE_W:0]   rate_full;
    logic signed [TURN_W-1:0] turns_new;

    always_comb begin
        diff      = $signed({2'b00, r_raw}) - $signed({2'b00, rec_rd.prev_raw});
        rate_full = diff;
        turns_new = rec_rd.turns;
        if (diff < JUMP_LO) begin
            rate_full = diff + TURN_STEP;
            if (rec_rd.turns < TURN_MAX) begin
                turns_new = rec_rd.turns + TURN_W'(1);
            end
        end else if (diff > JUMP_HI) begin
            rate_full = diff - TURN_STEP;
            if (rec_rd.turns > TURN_MIN) begin
                turns_new = rec_rd.turns - TURN_W'(1);
            end
        end
        ring_addr = RMAW'(r_ch_idx) * RMAW'(mtet_pkg::RING_DEPTH) + RMAW'(rec_rd.pos);
    end

    // ---------------------------------------------------------------
    // Ring stage: update running sum, build write-back record
    logic signed [RATE_W-1:0] ring_old;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [CONT_W-1:0] cont;

    always_comb begin
        ring_old = r_wrapped ? $signed(ring_rdata) : '0;
        sum_new  = r_sum_old - SUM_W'(ring_old) + SUM_W'(r_rate);
        cont     = CONT_W'($signed({r_turns_new, r_raw}));

        rec_wr.prev_raw = r_raw;
        rec_wr.turns    = r_turns_new;
        rec_wr.pos      = (r_pos == POS_LAST) ? '0 : r_pos + RING_AW'(1);
        rec_wr.wrapped  = r_wrapped || (r_pos == POS_LAST);
        rec_wr.sum      = sum_new;
    end

    // ---------------------------------------------------------------
    // Math stage operands
    logic [MEAN_N-1:0]             sum_mag;
    logic signed [CONT_W+DEG_W-1:0] angle_full;

    always_comb begin
        sum_mag    = MEAN_N'(r_sum_new[SUM_W-1] ? -r_sum_new : r_sum_new);
        angle_full = r_adiff * DEG;
    end

    // Final result
    logic [RATE_W-1:0]        mean_q;
    logic signed [RATE_W-1:0] mean_s;

    always_comb begin
        mean_q = RATE_W'(r_mean_prod >> mtet_pkg::MEAN_SH);
        mean_s = r_sum_neg ? -$signed(mean_q) : $signed(mean_q);
    end

    // ---------------------------------------------------------------
    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch_idx   <= CH_AW'(i_channel);
            r_in_range <= 32'(i_channel) < mtet_pkg::NUM_CHANNELS;
            r_rec_vld  <= (32'(i_channel) < mtet_pkg::NUM_CHANNELS)
                          && r_ch_vld[CH_AW'(i_channel)];
            r_raw      <= i_raw_angle;
            r_offset   <= (32'(i_channel) < mtet_pkg::NUM_OFFSET_REGS)
                          ? r_zero_offset[i_channel] : '0;
        end
        if (r_state == mtet_pkg::S_CHAN) begin
            r_rate      <= rate_full[RATE_W-1:0];
            r_turns_new <= turns_new;
            r_pos       <= rec_rd.pos;
            r_wrapped   <= rec_rd.wrapped;
            r_sum_old   <= rec_rd.sum;
            r_ring_addr <= ring_addr;
        end
        if (r_state == mtet_pkg::S_RING) begin
            r_sum_new <= sum_new;
            r_cont    <= cont;
            r_adiff   <= (CONT_W+1)'(cont) - $signed({{(CONT_W+1-RAW_W){1'b0}}, r_offset});
        end
        if (r_state == mtet_pkg::S_MATH) begin
            r_mean_prod <= (MEAN_N+RECIP_W)'(sum_mag) * (MEAN_N+RECIP_W)'(RECIP);
            r_sum_neg   <= r_sum_new[SUM_W-1];
            r_angle     <= angle_full[ANGLE_W-1:0];
        end
        if (out_load) begin
            r_o_rate  <= r_in_range ? r_rate      : '0;
            r_o_mean  <= r_in_range ? mean_s      : '0;
            r_o_turns <= r_in_range ? r_turns_new : '0;
            r_o_cont  <= r_in_range ? r_cont      : '0;
            r_o_angle <= r_in_range ? r_angle     : '0;
        end
    end

    // Channel valid bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_ch_vld[r_ch_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_rate        = r_o_rate;
    assign o_mean_rate        = r_o_mean;
    assign o_turn_count       = r_o_turns;
    assign o_continuous_count = r_o_cont;
    assign o_angle_deg_x8192  = r_o_angle;

endmodule

/* rtl/mtet_ram.sv */
// Simple dual-port RAM, one write port, one registered read port
module mtet_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/multi_turn_encoder_tracker_tb.sv */
module multi_turn_encoder_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtet_pkg::*;

    localparam int RAW_MAX      = (1 << RAW_W) - 1;
    localparam int CH_MAX       = (1 << CH_W) - 1;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int IDLE_PCT     = 25;
    localparam int TX_GAP_PCT   = 35;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 100;
    localparam int TAIL_CYCLES  = 12;
    // Spin pattern: park mid-turn, then hi/lo pairs that each cross one turn
    localparam int SPIN_PARK     = COUNTS_PER_TURN / 2;
    localparam int SPIN_LO_START = COUNTS_PER_TURN - JUMP_LIMIT - 2;
    localparam int SPIN_TURNS    = 15;

    // Register map of the write channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_OFFSET_CH0,
        REG_ZERO_OFFSET_CH1,
        REG_ZERO_OFFSET_CH2,
        REG_ZERO_OFFSET_CH3,
        REG_ZERO_OFFSET_CH4,
        REG_ZERO_OFFSET_CH5,
        REG_SPARE_A,
        REG_SPARE_B
    } cfg_reg_t;

    // One predicted result word, with the reading that caused it
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [RAW_W-1:0]   raw_angle;
        logic [RATE_W-1:0]  step_rate;
        logic [RATE_W-1:0]  mean_rate;
        logic [TURN_W-1:0]  turn_count;
        logic [CONT_W-1:0]  continuous_count;
        logic [ANGLE_W-1:0] angle_deg;
    } reading_t;

    // DUT connections
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [CH_W-1:0]        i_channel   = '0;
    logic [RAW_W-1:0]       i_raw_angle = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [RATE_W-1:0]  o_step_rate;
    logic signed [RATE_W-1:0]  o_mean_rate;
    logic signed [TURN_W-1:0]  o_turn_count;
    logic signed [CONT_W-1:0]  o_continuous_count;
    logic signed [ANGLE_W-1:0] o_angle_deg_x8192;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // Tracker state as the block should hold it
    logic [RAW_W-1:0]          last_raw   [NUM_CHANNELS];
    logic signed [TURN_W-1:0]  turn_cnt   [NUM_CHANNELS];
    logic signed [RATE_W-1:0]  rate_ring  [NUM_CHANNELS][RING_DEPTH];
    logic [RING_AW-1:0]        ring_slot  [NUM_CHANNELS];
    logic [RAW_W-1:0]          zero_offset[NUM_OFFSET_REGS];

    reading_t pending_readings[$];

    int  error_count     = 0;
    int  words_sent      = 0;
    int  words_off_range = 0;
    int  results_checked = 0;
    int  config_writes   = 0;
    int  cycle_count     = 0;
    bit  tx_steady       = 1'b0;
    bit  rx_steady       = 1'b0;
    int  holds_requested = 0;
    int  holds_served    = 0;
    int  hold_left       = 0;

    multi_turn_encoder_tracker u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_channel          (i_channel),
        .i_raw_angle        (i_raw_angle),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_step_rate        (o_step_rate),
        .o_mean_rate        (o_mean_rate),
        .o_turn_count       (o_turn_count),
        .o_continuous_count (o_continuous_count),
        .o_angle_deg_x8192  (o_angle_deg_x8192),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Unwrap one reading, update the tracked state and build its result word
    function automatic reading_t unwrap_reading(input logic [CH_W-1:0] ch,
                                                input logic [RAW_W-1:0] raw);
        reading_t r;
        int       c;
        int       diff;
        int       rate;
        int       sum;
        longint   cont;
        longint   angle;
        r = '0;
        r.channel   = ch;
        r.raw_angle = raw;
        // unknown channel: zero word, no state touched
        if (ch >= NUM_CHANNELS) return r;
        c    = int'(ch);
        diff = int'(raw) - int'(last_raw[c]);
        last_raw[c] = raw;
        if (diff < -JUMP_LIMIT) begin
            if (turn_cnt[c] < TURN_LIMIT) turn_cnt[c] = turn_cnt[c] + TURN_W'(1);
            rate = diff + COUNTS_PER_TURN;
        end else if (diff > JUMP_LIMIT) begin
            if (turn_cnt[c] > -TURN_LIMIT) turn_cnt[c] = turn_cnt[c] - TURN_W'(1);
            rate = diff - COUNTS_PER_TURN;
        end else begin
            rate = diff;
        end
        rate_ring[c][ring_slot[c]] = RATE_W'(rate);
        if (int'(ring_slot[c]) >= RING_DEPTH - 1) ring_slot[c] = '0;
        else ring_slot[c] = ring_slot[c] + 1'b1;
        sum = 0;
        for (int k = 0; k < RING_DEPTH; k++) sum += rate_ring[c][k];
        // int division truncates toward zero
        cont  = longint'(raw) + longint'(turn_cnt[c]) * COUNTS_PER_TURN;
        angle = (cont - longint'(zero_offset[c])) * DEG_PER_TURN;
        r.step_rate        = RATE_W'(rate);
        r.mean_rate        = RATE_W'(sum / RING_DEPTH);
        r.turn_count       = TURN_W'(turn_cnt[c]);
        r.continuous_count = CONT_W'(cont);
        r.angle_deg        = ANGLE_W'(angle);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want_v, input longint got_v,
                               input reading_t want);
        if (want_v != got_v) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t ERROR ch %0d raw %0d %s: expected %0d, actual %0d",
                         $time, want.channel, want.raw_angle, name, want_v, got_v);
            if (error_count == MAX_REPORTS)
                $display("%0t further mismatch reports suppressed", $time);
        end
    endtask

    // Result checker: every accepted word against the oldest prediction
    always @(posedge i_clk) begin : result_check
        reading_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_readings.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ERROR unexpected result word: expected none, actual rate %0d",
                             $time, o_step_rate);
            end else begin
                want = pending_readings.pop_front();
                check_field("step_rate", $signed(want.step_rate), o_step_rate, want);
                check_field("mean_rate", $signed(want.mean_rate), o_mean_rate, want);
                check_field("turn_count", $signed(want.turn_count), o_turn_count, want);
                check_field("continuous_count", $signed(want.continuous_count),
                            o_continuous_count, want);
                check_field("angle_deg_x8192", $signed(want.angle_deg),
                            o_angle_deg_x8192, want);
            end
        end
    end

    // Result-side ready: random stalls, steady stretches, requested long holds
    always @(posedge i_clk) begin
        if (holds_served != holds_requested) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t ERROR timeout after %0d cycles, %0d results outstanding",
                 $time, LIMIT_CYCLES, pending_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one word, hold it until accepted, then log its prediction
    task automatic send_word(input logic [CH_W-1:0] ch, input logic [RAW_W-1:0] raw);
        if (!tx_steady && $urandom_range(0, 99) < TX_GAP_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_raw_angle <= raw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_readings.push_back(unwrap_reading(ch, raw));
        words_sent++;
        if (ch >= NUM_CHANNELS) words_off_range++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    // Register write; only called with the block idle
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (int'(idx) < NUM_OFFSET_REGS) zero_offset[int'(idx)] = data[RAW_W-1:0];
        config_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_offsets(input int mode);
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i < NUM_OFFSET_REGS; i++) begin
            case (mode)
                0: data = '0;
                1: data = CFG_DATA_W'(RAW_MAX);
                default: data = CFG_DATA_W'($urandom);
            endcase
            write_register(cfg_reg_t'(int'(REG_ZERO_OFFSET_CH0) + i), data);
        end
        // writes past the map must be ignored
        write_register(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                       CFG_DATA_W'($urandom));
    endtask

    task automatic apply_reset();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            last_raw[c]  = '0;
            turn_cnt[c]  = '0;
            ring_slot[c] = '0;
            for (int k = 0; k < RING_DEPTH; k++) rate_ring[c][k] = '0;
        end
        for (int i = 0; i < NUM_OFFSET_REGS; i++) zero_offset[i] = '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Random word: mostly plausible motion, some threshold hits, some noise
    task automatic send_random_word();
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        int               pick;
        int               step;
        int               prev;
        pick = $urandom_range(0, 99);
        if (pick < 8) ch = CH_W'($urandom_range(NUM_CHANNELS, CH_MAX));
        else ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
        pick = $urandom_range(0, 99);
        if (ch >= NUM_CHANNELS || pick < 12) begin
            raw = RAW_W'($urandom);
        end else begin
            prev = int'(last_raw[int'(ch)]);
            step = $urandom_range(0, 1800);
            step = step - 900;
            if (pick < 22) begin
                // jump right at the unwrap limit, either side
                step = JUMP_LIMIT + int'($urandom_range(0, 1));
                if (prev + step <= RAW_MAX) raw = RAW_W'(prev + step);
                else if (prev - step >= 0) raw = RAW_W'(prev - step);
                else raw = RAW_W'(prev + step);
            end else begin
                // modulo wrap gives natural turn crossings
                raw = RAW_W'(prev + step);
            end
        end
        send_word(ch, raw);
    endtask

    // Drive one channel across many turns in one direction, two words per turn
    task automatic spin_channel(input logic [CH_W-1:0] ch, input bit reverse,
                                input int turns_to_go);
        int lo;
        lo = -1;
        for (int n = 0; n < turns_to_go; n++) begin
            if (lo < 0) begin
                send_word(ch, RAW_W'(reverse ? RAW_MAX - SPIN_PARK : SPIN_PARK));
                lo = SPIN_LO_START;
            end
            send_word(ch, RAW_W'(reverse ? RAW_MAX - (lo + JUMP_LIMIT + 1)
                                         : lo + JUMP_LIMIT + 1));
            send_word(ch, RAW_W'(reverse ? RAW_MAX - lo : lo));
            lo--;
        end
    endtask

    // First readings after reset with offsets at zero; unknown channels
    task automatic test_first_readings();
        send_word(CH_W'(0), RAW_W'(0));
        send_word(CH_W'(1), RAW_W'(RAW_MAX));
        send_word(CH_W'(2), RAW_W'(JUMP_LIMIT));
        send_word(CH_W'(3), RAW_W'(JUMP_LIMIT + 1));
        send_word(CH_W'(NUM_CHANNELS), RAW_W'(RAW_MAX));
        send_word(CH_W'(CH_MAX), RAW_W'($urandom));
        send_word(CH_W'(2), RAW_W'(0));
        send_word(CH_W'(2), RAW_W'(JUMP_LIMIT + 1));
        send_word(CH_W'(2), RAW_W'(0));
        send_word(CH_W'(1), RAW_W'(0));
        send_word(CH_W'(5), RAW_W'(RAW_MAX));
        send_word(CH_W'(4), RAW_W'(SPIN_PARK));
        wait_all_results();
    endtask

    // Offset extremes, data with high bits set, writes past the map
    task automatic test_offset_extremes();
        write_register(REG_ZERO_OFFSET_CH0, CFG_DATA_W'(RAW_MAX));
        write_register(REG_ZERO_OFFSET_CH1, '1);
        write_register(REG_ZERO_OFFSET_CH2, '0);
        write_register(REG_ZERO_OFFSET_CH3, 16'hE4D2);
        write_register(REG_ZERO_OFFSET_CH4, CFG_DATA_W'(SPIN_PARK));
        write_register(REG_ZERO_OFFSET_CH5, CFG_DATA_W'(RAW_MAX));
        write_register(REG_SPARE_A, '1);
        write_register(REG_SPARE_B, CFG_DATA_W'($urandom));
        send_word(CH_W'(0), RAW_W'(0));
        send_word(CH_W'(0), RAW_W'(RAW_MAX));
        send_word(CH_W'(1), RAW_W'(0));
        send_word(CH_W'(2), RAW_W'(RAW_MAX));
        send_word(CH_W'(3), RAW_W'(1234));
        send_word(CH_W'(4), RAW_W'(SPIN_PARK));
        send_word(CH_W'(5), RAW_W'(0));
        send_word(CH_W'(NUM_CHANNELS + 1), RAW_W'(0));
        wait_all_results();
    endtask

    // Many turns in both directions, on the last two channels
    task automatic test_multi_turn_spin();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        spin_channel(CH_W'(NUM_CHANNELS - 2), 1'b0, SPIN_TURNS);
        spin_channel(CH_W'(NUM_CHANNELS - 1), 1'b1, SPIN_TURNS);
        wait_all_results();
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // Random traffic in phases, offsets changed between phases
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_all_offsets((phase == 3) ? 2 : phase + 1);
            // one phase runs with no idling on either side
            tx_steady = (phase == 2);
            rx_steady <= (phase == 2);
            repeat (150) send_random_word();
            wait_all_results();
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_output_backpressure();
        holds_requested <= holds_requested + 1;
        tx_steady = 1'b1;
        repeat (30) send_random_word();
        tx_steady = 1'b0;
        wait_all_results();
    endtask

    // Sender goes quiet until the block has drained, then resumes
    task automatic test_sender_pause();
        repeat (20) send_random_word();
        wait_all_results();
        repeat (20) send_random_word();
        wait_all_results();
    endtask

    initial begin
        apply_reset();
        test_first_readings();
        test_offset_extremes();
        test_multi_turn_spin();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d input words (%0d on unknown channels), %0d result words,",
                 words_sent, words_off_range, results_checked);
        $display("%0d register writes, %0d-turn spins in both directions, output stalls",
                 config_writes, SPIN_TURNS);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
